@@ sv/crs_pkg.sv @@
// Shared types and constants for the combination range splitter.
// Holds the sequencer state and job enums, register codes and datapath widths.
// No dependencies.
package crs_pkg;

  localparam int MASK_W        = 256;            // widest mask, bits
  localparam int WORK_W        = 272;            // binomial work register, bits
  localparam int WORK_BYTES    = WORK_W / 8;     // bytes walked by each multiply or divide pass
  localparam int BITS_PER_BYTE = 8;
  localparam int IDX_W         = 32;
  localparam int DEF_MAX_KEY_BYTES = 32;

  localparam logic [1:0] REG_KEY_BYTES      = 2'd0;
  localparam logic [1:0] REG_MISMATCH_COUNT = 2'd1;
  localparam logic [1:0] REG_CHUNK_COUNT    = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TCHK,
    S_MUL,
    S_DIV,
    S_CDIV,
    S_PREP,
    S_OMUL,
    S_CMP,
    S_SAVE,
    S_OUT0,
    S_OUT1
  } state_t;

  typedef enum logic [1:0] {
    JOB_TOT,
    JOB_B0,
    JOB_UNR
  } job_t;

endpackage

@@ sv/combination_range_splitter.sv @@
// Top level of the combination range splitter: digit-serial combinadic unranking.
// Uses crs_pkg for the state enums, register codes and datapath widths.
//
// Usage: a beat on the item channel (item_valid high, item_stall low) carries one
// chunk_index. The block then produces two beats on the result channel: the
// chunk's start mask (is_end_mask 0) followed by its end mask (is_end_mask 1),
// each as four 64-bit limbs. An index not below chunk_count gives two all-zero
// masks with index_error set, the first offered in the cycle after the input beat.
// One item at a time. The binomial C(N,k) is built by a byte-serial
// multiply-by-small and divide-by-small unit; each pass walks the 34-byte
// work register. An item runs min(k,N-k) multiply-and-divide steps for the
// total, one more for C(N-1,k), a bit-serial divide by chunk_count, and for
// each mask that is not a fixed boundary a shift-and-add multiply by the index
// and a multiply-and-divide step per bit scanned. The scan of each unranking
// stops early once all k bits are placed.
// item_stall stays high from the accepted beat until the end mask is taken.
// While the receiver holds result_stall high the pending mask simply waits in
// its register. Reset (rst, synchronous) returns the sequencer to idle and sets
// key_bytes 32, mismatch_count 0 and chunk_count 1. Configuration writes are
// taken in any cycle but must only be issued while the block is idle.
module combination_range_splitter
  import crs_pkg::*;
#(
  parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [31:0] chunk_index,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [63:0] mask_limb0,
  output logic [63:0] mask_limb1,
  output logic [63:0] mask_limb2,
  output logic [63:0] mask_limb3,
  output logic        is_end_mask,
  output logic        index_error
);

  // Configuration registers.
  logic [5:0]  key_bytes;
  logic [8:0]  mismatch_count;
  logic [31:0] chunk_count;

  state_t state, state_next;
  job_t   job;

  logic [WORK_W-1:0] work;     // binomial being updated, shifts one byte a cycle
  logic [MASK_W-1:0] acc;      // total, then chunk size
  logic [MASK_W-1:0] b0;       // C(N-1, k), seed of every unranking
  logic [MASK_W-1:0] mc;       // shifted multiplicand for chunk * index
  logic [MASK_W-1:0] ordv;     // remaining ordinal during unranking
  logic [MASK_W-1:0] mask;
  logic [MASK_W-1:0] smask;
  logic [MASK_W-1:0] emask;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  mb;
  logic [31:0]       crem;     // remainder of the divide by chunk_count
  logic [8:0]        n;
  logic [8:0]        k;
  logic [8:0]        t;
  logic [7:0]        i;
  logic [8:0]        kl;       // bits still to place
  logic [7:0]        b;        // bit position under test
  logic [8:0]        mul_m;
  logic [8:0]        div_d;
  logic [8:0]        carry;    // multiply carry, then divide remainder
  logic [8:0]        cnt;
  logic              phase;    // 0 while working on the start mask
  logic              err;

  // Saturated geometry of the current configuration.
  logic [5:0] kb_sat;
  logic [8:0] n_cfg;
  logic [8:0] k_cfg;
  logic       in_accept;
  logic       in_err;

  always_comb begin
    kb_sat = key_bytes;
    if (kb_sat == 6'd0) begin
      kb_sat = 6'd1;
    end
    if (kb_sat > 6'(MAX_KEY_BYTES)) begin
      kb_sat = 6'(MAX_KEY_BYTES);
    end
    n_cfg = {kb_sat, 3'b000};
    k_cfg = (mismatch_count > n_cfg) ? n_cfg : mismatch_count;
  end

  assign in_accept = item_valid && !item_stall;
  assign in_err    = ({1'b0, chunk_index} >= {1'b0, chunk_count});

  // One radix-256 step of a division by a 9-bit divisor: eight restoring
  // steps on narrow values. Returns {quotient byte, remainder}.
  function automatic logic [16:0] div_byte(input logic [8:0] r_in,
                                           input logic [7:0] byte_in,
                                           input logic [8:0] d);
    logic [9:0] r;
    logic [7:0] q;
    r = {1'b0, r_in};
    q = '0;
    for (int j = 7; j >= 0; j--) begin
      r = {r[8:0], byte_in[j]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[j] = 1'b1;
      end
    end
    return {q, r[8:0]};
  endfunction

  logic [16:0] mul_prod;
  logic [16:0] div_res;
  logic [32:0] cdiv_cur;
  logic        cdiv_q;
  logic        take;
  logic        mul_done;
  logic        cdiv_done;
  logic        omul_done;
  logic        special;
  logic [MASK_W-1:0] first_mask;
  logic [MASK_W-1:0] last_mask;
  logic [8:0]  n_minus_k;

  assign mul_prod  = 17'(work[7:0]) * 17'(mul_m) + 17'(carry);
  assign div_res   = div_byte(carry, work[WORK_W-1 -: 8], div_d);
  assign cdiv_cur  = {crem, acc[MASK_W-1]};
  assign cdiv_q    = (cdiv_cur >= {1'b0, chunk_count});
  assign take      = (ordv >= work[MASK_W-1:0]);
  assign mul_done  = (cnt == 9'(WORK_BYTES - 1));
  assign cdiv_done = (cnt == 9'(MASK_W - 1));
  assign omul_done = (cnt == 9'(IDX_W - 1));
  assign special   = phase ? (idx == chunk_count - 32'd1) : (idx == '0);
  assign n_minus_k = n - k;

  // Fixed boundary masks: the lowest k bits, or the highest k bits of the space.
  always_comb begin
    for (int p = 0; p < MASK_W; p++) begin
      first_mask[p] = (9'(p) < k);
      last_mask[p]  = (9'(p) >= n_minus_k) && (9'(p) < n);
    end
  end

  // Configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes      <= 6'd32;
      mismatch_count <= '0;
      chunk_count    <= 32'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KEY_BYTES:      key_bytes      <= cfg_data[5:0];
        REG_MISMATCH_COUNT: mismatch_count <= cfg_data[8:0];
        REG_CHUNK_COUNT:    chunk_count    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    item_stall   = 1'b1;
    result_valid = 1'b0;
    is_end_mask  = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          state_next = in_err ? S_OUT0 : S_TCHK;
        end
      end
      S_TCHK: state_next = S_MUL;
      S_MUL:  if (mul_done) state_next = S_DIV;
      S_DIV: begin
        if (mul_done) begin
          unique case (job)
            JOB_TOT: state_next = S_TCHK;
            JOB_B0:  state_next = S_CDIV;
            JOB_UNR: state_next = S_CMP;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_CDIV: if (cdiv_done) state_next = S_PREP;
      S_PREP: state_next = special ? S_SAVE : S_OMUL;
      S_OMUL: if (omul_done) state_next = S_CMP;
      S_CMP: begin
        if (kl == '0 || b == '0 || (take && kl == 9'd1)) begin
          state_next = S_SAVE;
        end else begin
          state_next = S_MUL;
        end
      end
      S_SAVE: state_next = phase ? S_OUT0 : S_PREP;
      S_OUT0: begin
        result_valid = 1'b1;
        if (!result_stall) state_next = S_OUT1;
      end
      S_OUT1: begin
        result_valid = 1'b1;
        is_end_mask  = 1'b1;
        if (!result_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath. S_TCHK also starts the C(N-1,k) job once the total is complete.
  always_ff @(posedge clk) begin
    if (rst) begin
      job   <= JOB_TOT;
      phase <= 1'b0;
      err   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            idx   <= chunk_index;
            n     <= n_cfg;
            k     <= k_cfg;
            t     <= (k_cfg < n_cfg - k_cfg) ? k_cfg : n_cfg - k_cfg;
            i     <= '0;
            work  <= WORK_W'(1);
            phase <= 1'b0;
            err   <= in_err;
            smask <= '0;
            emask <= '0;
          end
        end
        S_TCHK: begin
          cnt   <= '0;
          carry <= '0;
          if (9'(i) == t) begin
            acc   <= work[MASK_W-1:0];
            job   <= JOB_B0;
            mul_m <= n_minus_k;
            div_d <= n;
          end else begin
            job   <= JOB_TOT;
            mul_m <= n - 9'(i);
            div_d <= 9'(i) + 9'd1;
          end
        end
        S_MUL: begin
          work  <= {mul_prod[7:0], work[WORK_W-1:8]};
          carry <= mul_done ? '0 : mul_prod[16:8];
          cnt   <= mul_done ? '0 : cnt + 9'd1;
        end
        S_DIV: begin
          work  <= {work[WORK_W-9:0], div_res[16:9]};
          carry <= div_res[8:0];
          cnt   <= mul_done ? '0 : cnt + 9'd1;
          if (mul_done) begin
            unique case (job)
              JOB_TOT: i <= i + 8'd1;
              JOB_B0: begin
                b0   <= {work[MASK_W-9:0], div_res[16:9]};
                crem <= '0;
              end
              JOB_UNR: b <= b - 8'd1;
              default: ;
            endcase
          end
        end
        S_CDIV: begin
          crem <= cdiv_q ? 32'(cdiv_cur - {1'b0, chunk_count}) : cdiv_cur[31:0];
          acc  <= {acc[MASK_W-2:0], cdiv_q};
          cnt  <= cdiv_done ? '0 : cnt + 9'd1;
        end
        S_PREP: begin
          if (special) begin
            mask <= phase ? last_mask : first_mask;
          end else begin
            mb   <= phase ? idx + 32'd1 : idx;
            mc   <= acc;
            ordv <= '0;
            cnt  <= '0;
          end
        end
        S_OMUL: begin
          if (mb[0]) ordv <= ordv + mc;
          mc  <= {mc[MASK_W-2:0], 1'b0};
          mb  <= {1'b0, mb[IDX_W-1:1]};
          cnt <= omul_done ? '0 : cnt + 9'd1;
          if (omul_done) begin
            work <= {{(WORK_W - MASK_W){1'b0}}, b0};
            b    <= 8'(n - 9'd1);
            kl   <= k;
            mask <= '0;
          end
        end
        S_CMP: begin
          job   <= JOB_UNR;
          cnt   <= '0;
          carry <= '0;
          div_d <= {1'b0, b};
          if (kl != '0) begin
            if (take) begin
              ordv    <= ordv - work[MASK_W-1:0];
              mask[b] <= 1'b1;
              mul_m   <= kl;
              kl      <= kl - 9'd1;
            end else begin
              mul_m <= (kl >= {1'b0, b}) ? 9'd0 : {1'b0, b} - kl;
            end
          end
        end
        S_SAVE: begin
          if (phase) begin
            emask <= mask;
          end else begin
            smask <= mask;
          end
          phase <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  logic [MASK_W-1:0] mask_out;
  assign mask_out    = (state == S_OUT1) ? emask : smask;
  assign mask_limb0  = mask_out[63:0];
  assign mask_limb1  = mask_out[127:64];
  assign mask_limb2  = mask_out[191:128];
  assign mask_limb3  = mask_out[255:192];
  assign index_error = err;

  // While a result is offered no new item may enter.
  a_busy_while_out: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("item accepted while a result is pending");

  // An out-of-range index must give all-zero masks.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && index_error) |-> (mask_limb0 == '0 && mask_limb1 == '0 &&
                                       mask_limb2 == '0 && mask_limb3 == '0))
    else $error("error result with nonzero mask");

  // The first beat of a pair is always the start mask.
  a_start_first: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !is_end_mask)
    else $error("end mask delivered before start mask");

  // After the end mask is taken the channel goes quiet.
  a_pair_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && is_end_mask && !result_stall) |=> !result_valid)
    else $error("extra result after end mask");

endmodule

@@ test/tb_top.sv @@
// Testbench for combination_range_splitter: a directed part and a random part.
// Predicts both boundary masks of every chunk and checks each result beat in order.
// Depends on crs_pkg for the register codes.
`timescale 1ns / 1ps

module tb_top;
  import crs_pkg::*;

  typedef logic [319:0] wide_t;

  typedef struct {
    logic [255:0] mask;
    logic         is_end;
    logic         err;
  } mask_beat_t;

  // The slowest item (256-bit space, k near 128) runs with no beat at all;
  // the limit must lie above that stretch.
  localparam int QUIET_LIMIT = 250000;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        item_valid;
  logic        item_stall;
  logic [31:0] chunk_index;
  logic        result_valid;
  logic        result_stall;
  logic [63:0] mask_limb0, mask_limb1, mask_limb2, mask_limb3;
  logic        is_end_mask;
  logic        index_error;

  // Local copy of the register file.
  logic [5:0]  key_bytes_q;
  logic [8:0]  mismatch_q;
  logic [31:0] chunk_count_q;

  mask_beat_t  pending_masks[$];
  int          fail_count;
  int          idle_cycles;
  bit          no_idle;

  combination_range_splitter dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall), .chunk_index(chunk_index),
    .result_valid(result_valid), .result_stall(result_stall),
    .mask_limb0(mask_limb0), .mask_limb1(mask_limb1),
    .mask_limb2(mask_limb2), .mask_limb3(mask_limb3),
    .is_end_mask(is_end_mask), .index_error(index_error)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Binomial coefficient built the same way the block does it: multiply, then
  // divide exactly, over the smaller of k and n-k.
  function automatic wide_t binomial(int unsigned n, int unsigned k);
    wide_t r;
    int unsigned t;
    if (k > n) return '0;
    t = (n - k < k) ? n - k : k;
    r = 1;
    for (int unsigned i = 0; i < t; i++) begin
      r = r * wide_t'(n - i);
      r = r / wide_t'(i + 1);
    end
    return r;
  endfunction

  // Greedy combinadic unranking: scan bits from the top, set a bit whenever
  // the remaining ordinal reaches C(bit, bits still to place).
  function automatic logic [255:0] unrank_mask(wide_t ord, int unsigned k,
                                               int unsigned n);
    logic [255:0] m;
    wide_t rem;
    wide_t b;
    int unsigned bitpos;
    m = '0;
    rem = ord;
    bitpos = n;
    while (bitpos > 0 && k > 0) begin
      bitpos--;
      b = binomial(bitpos, k);
      if (rem >= b) begin
        rem = rem - b;
        m[bitpos] = 1'b1;
        k--;
      end
    end
    return m;
  endfunction

  // Works out the start and end beats for one chunk index under the
  // current register settings and queues them.
  task automatic predict_chunk_bounds(logic [31:0] idx);
    int unsigned kb;
    int unsigned n;
    int unsigned k;
    wide_t chunk;
    mask_beat_t s;
    mask_beat_t e;
    kb = key_bytes_q;
    if (kb < 1) kb = 1;
    if (kb > 32) kb = 32;
    n = kb * 8;
    k = mismatch_q;
    if (k > n) k = n;
    s.mask = '0; s.is_end = 1'b0; s.err = 1'b0;
    e.mask = '0; e.is_end = 1'b1; e.err = 1'b0;
    if (idx >= chunk_count_q) begin
      // Out of range, including a chunk count of zero: both masks zero.
      s.err = 1'b1;
      e.err = 1'b1;
    end else begin
      chunk = binomial(n, k) / wide_t'(chunk_count_q);
      if (idx == 0) begin
        for (int unsigned i = 0; i < k; i++) s.mask[i] = 1'b1;
      end else begin
        s.mask = unrank_mask(chunk * wide_t'(idx), k, n);
      end
      if (idx == chunk_count_q - 1) begin
        for (int unsigned i = n - k; i < n; i++) e.mask[i] = 1'b1;
      end else begin
        e.mask = unrank_mask(chunk * wide_t'(idx + 1), k, n);
      end
    end
    pending_masks.push_back(s);
    pending_masks.push_back(e);
  endtask

  // Sends one chunk index, with a random gap in front unless idling is off.
  // Valid is left high after the beat so back-to-back items need no toggle.
  task automatic send_chunk(logic [31:0] idx);
    if (!no_idle && $urandom_range(99) < 29) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    predict_chunk_bounds(idx);
    item_valid  <= 1'b1;
    chunk_index <= idx;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // Waits until every predicted beat has come back, then lets the block settle.
  task automatic drain;
    item_valid <= 1'b0;
    while (pending_masks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_KEY_BYTES:      key_bytes_q   = value[5:0];
      REG_MISMATCH_COUNT: mismatch_q    = value[8:0];
      REG_CHUNK_COUNT:    chunk_count_q = value;
      default: ;
    endcase
  endtask

  task automatic configure(logic [31:0] kb, logic [31:0] k, logic [31:0] count);
    write_reg(REG_KEY_BYTES, kb);
    write_reg(REG_MISMATCH_COUNT, k);
    write_reg(REG_CHUNK_COUNT, count);
  endtask

  // Result side: random stall, and an in-order check of every accepted beat.
  always @(posedge clk) begin
    mask_beat_t exp_beat;
    logic [255:0] got;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        got = {mask_limb3, mask_limb2, mask_limb1, mask_limb0};
        if (pending_masks.size() == 0) begin
          $error("result beat with nothing expected: mask %h", got);
          fail_count++;
        end else begin
          exp_beat = pending_masks.pop_front();
          if (got[63:0] !== exp_beat.mask[63:0]) begin
            $error("mask_limb0 expected %h actual %h", exp_beat.mask[63:0], got[63:0]);
            fail_count++;
          end
          if (got[127:64] !== exp_beat.mask[127:64]) begin
            $error("mask_limb1 expected %h actual %h", exp_beat.mask[127:64],
                   got[127:64]);
            fail_count++;
          end
          if (got[191:128] !== exp_beat.mask[191:128]) begin
            $error("mask_limb2 expected %h actual %h", exp_beat.mask[191:128],
                   got[191:128]);
            fail_count++;
          end
          if (got[255:192] !== exp_beat.mask[255:192]) begin
            $error("mask_limb3 expected %h actual %h", exp_beat.mask[255:192],
                   got[255:192]);
            fail_count++;
          end
          if (is_end_mask !== exp_beat.is_end) begin
            $error("is_end_mask expected %b actual %b", exp_beat.is_end, is_end_mask);
            fail_count++;
          end
          if (index_error !== exp_beat.err) begin
            $error("index_error expected %b actual %b", exp_beat.err, index_error);
            fail_count++;
          end
        end
      end
      result_stall <= !no_idle && ($urandom_range(99) < 29);
    end
  end

  // Watchdog: counts cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Reset values: 256-bit space, no set bits, a single chunk.
  task automatic test_reset_defaults;
    send_chunk(32'd0);
    send_chunk(32'd1);
    send_chunk(32'hFFFF_FFFF);
    drain();
  endtask

  // Every index of a small split, plus the first out-of-range one.
  task automatic test_small_split;
    configure(32'd1, 32'd3, 32'd5);
    for (int i = 0; i <= 5; i++) send_chunk(i);
    drain();
  endtask

  // Saturation of key length and mismatch count, and a full-width mask.
  task automatic test_saturation;
    configure(32'd2, 32'd16, 32'd1);
    send_chunk(32'd0);
    drain();
    // Key length zero acts as one byte; the mismatch count clips to 8.
    configure(32'd0, 32'd300, 32'd3);
    send_chunk(32'd0);
    send_chunk(32'd2);
    drain();
    configure(32'hFFFF_FFFF, 32'h0000_01FF, 32'd2);
    send_chunk(32'd1);
    drain();
    // Key length above the maximum saturates to 32 bytes.
    configure(32'd63, 32'd2, 32'd7);
    send_chunk(32'd0);
    send_chunk(32'd6);
    send_chunk(32'd3);
    drain();
  endtask

  // Chunk count zero rejects everything; a huge count makes the chunk size zero.
  task automatic test_chunk_count_extremes;
    configure(32'd1, 32'd4, 32'd0);
    send_chunk(32'd0);
    drain();
    write_reg(REG_CHUNK_COUNT, 32'hFFFF_FFFF);
    send_chunk(32'd0);
    send_chunk(32'd5);
    send_chunk(32'hFFFF_FFFE);
    send_chunk(32'hFFFF_FFFF);
    drain();
  endtask

  // One item at the heaviest point of the largest space.
  task automatic test_widest_space;
    configure(32'd32, 32'd128, 32'd3);
    send_chunk(32'd1);
    drain();
  endtask

  // Random settings, mostly small spaces so the run stays short.
  task automatic test_random_splits;
    logic [31:0] kb;
    logic [31:0] k;
    logic [31:0] count;
    logic [31:0] idx;
    int unsigned n;
    int unsigned pick;
    for (int phase = 0; phase < 12; phase++) begin
      // A stretch with no idling on either side.
      no_idle = (phase < 2);
      pick = $urandom_range(99);
      if (pick < 5) begin
        kb = $urandom;                 // any length, few set bits
        k  = $urandom_range(0, 3);
      end else begin
        kb = {26'($urandom_range(0, 67108863)), 6'd0} | $urandom_range(1, 2);
        n  = (kb[5:0] == 0) ? 8 : kb[5:0] * 8;
        k  = ($urandom_range(99) < 10)
             ? {23'($urandom_range(0, 8388607)), 9'(n + 1)}
             : $urandom_range(0, n);
      end
      pick = $urandom_range(99);
      if (pick < 50)      count = $urandom_range(1, 12);
      else if (pick < 80) count = $urandom;
      else if (pick < 90) count = 32'hFFFF_FFFF;
      else                count = 32'd0;
      configure(kb, k, count);
      for (int i = 0; i < 10; i++) begin
        if (count != 0 && $urandom_range(99) < 70) idx = $urandom_range(0, count - 1);
        else idx = $urandom;
        send_chunk(idx);
      end
      drain();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    item_valid   = 1'b0;
    chunk_index  = '0;
    fail_count   = 0;
    no_idle      = 1'b0;
    key_bytes_q   = 6'd32;
    mismatch_q    = 9'd0;
    chunk_count_q = 32'd1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_small_split();
    test_saturation();
    test_chunk_count_extremes();
    test_widest_space();
    test_random_splits();
    drain();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ combination_range_splitter.f @@
sv/crs_pkg.sv
sv/combination_range_splitter.sv
test/tb_top.sv
